/* src/tasr_pkg.sv */
`default_nettype none

package tasr_pkg;

  // Default fraction width of the axis components.
  localparam int FRAC_BITS_DEFAULT = 14;

  // Angle arithmetic in units of 1/64 degree.
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int ANGLE_W      = 17;  // negated 16-bit angle
  localparam int REM_W        = 13;  // remainder within one quadrant
  localparam int ANGLE_SHIFT  = 10;  // 1/64 degree to Q16 degree

  // Rotation-mode CORDIC data path.
  localparam int CORDIC_STAGES = 18;
  localparam int XY_W          = 33;  // Q30 vector with headroom
  localparam int Z_W           = 25;  // Q16 degree residual angle
  localparam int RND_W         = 34;  // rounding and saturation width
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // Axis direction codes.
  localparam logic [2:0] AXIS_POS_Z = 3'd0;
  localparam logic [2:0] AXIS_NEG_Z = 3'd1;
  localparam logic [2:0] AXIS_POS_X = 3'd2;
  localparam logic [2:0] AXIS_NEG_X = 3'd3;
  localparam logic [2:0] AXIS_POS_Y = 3'd4;
  localparam logic [2:0] AXIS_NEG_Y = 3'd5;

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Information that travels beside the CORDIC vector.
  typedef struct packed {
    logic [2:0] idx;
    logic [1:0] quad;
  } side_t;

  // atan(2^-i) in Q16 degrees.
  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 25'sd2949120;
      1:       v = 25'sd1740967;
      2:       v = 25'sd919879;
      3:       v = 25'sd466945;
      4:       v = 25'sd234379;
      5:       v = 25'sd117304;
      6:       v = 25'sd58666;
      7:       v = 25'sd29335;
      8:       v = 25'sd14668;
      9:       v = 25'sd7334;
      10:      v = 25'sd3667;
      11:      v = 25'sd1833;
      12:      v = 25'sd917;
      13:      v = 25'sd458;
      14:      v = 25'sd229;
      15:      v = 25'sd115;
      16:      v = 25'sd57;
      17:      v = 25'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/tasr_front.sv */
`default_nettype none

module tasr_front
  import tasr_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  input  wire  signed [15:0]          normal_x,
  input  wire  signed [15:0]          normal_y,
  input  wire  signed [15:0]          normal_z,
  input  wire  signed [15:0]          rotation_deg,
  output logic                        out_valid,
  output side_t                       out_side,
  output logic signed [Z_W-1:0]       out_z
);

  logic signed [ANGLE_W-1:0] dots [6];
  logic signed [ANGLE_W-1:0] best;
  logic [2:0]                sel_idx;
  logic signed [ANGLE_W-1:0] sel_angle;

  logic                      s1_valid;
  logic [2:0]                s1_idx;
  logic signed [ANGLE_W-1:0] s1_angle;

  logic signed [ANGLE_W:0]   mod_angle;
  logic [14:0]               turn_pos;
  logic [1:0]                quad;
  logic [REM_W-1:0]          rem;

  // Pick the first direction with the strictly largest positive dot product.
  always_comb begin
    dots[0] = ANGLE_W'(normal_z);
    dots[1] = -ANGLE_W'(normal_z);
    dots[2] = ANGLE_W'(normal_x);
    dots[3] = -ANGLE_W'(normal_x);
    dots[4] = ANGLE_W'(normal_y);
    dots[5] = -ANGLE_W'(normal_y);
    best    = '0;
    sel_idx = AXIS_POS_Z;
    for (int i = 0; i < 6; i++) begin
      if (dots[i] > best) begin
        best    = dots[i];
        sel_idx = 3'(i);
      end
    end
    // The y pair turns the other way.
    if (sel_idx == AXIS_POS_Y || sel_idx == AXIS_NEG_Y) begin
      sel_angle = -ANGLE_W'(rotation_deg);
    end else begin
      sel_angle = ANGLE_W'(rotation_deg);
    end
  end

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= sel_idx;
    s1_angle <= sel_angle;
  end

  // Reduce the angle into one full turn and split off the quadrant.
  always_comb begin
    if (s1_angle >= FULL_TURN) begin
      mod_angle = (ANGLE_W+1)'(s1_angle) - (ANGLE_W+1)'(FULL_TURN);
    end else if (s1_angle < -FULL_TURN) begin
      mod_angle = (ANGLE_W+1)'(s1_angle) + (ANGLE_W+1)'(2 * FULL_TURN);
    end else if (s1_angle < 0) begin
      mod_angle = (ANGLE_W+1)'(s1_angle) + (ANGLE_W+1)'(FULL_TURN);
    end else begin
      mod_angle = (ANGLE_W+1)'(s1_angle);
    end
    turn_pos = mod_angle[14:0];
    if (turn_pos >= 15'(3 * QUARTER_TURN)) begin
      quad = QUAD_3;
      rem  = REM_W'(turn_pos - 15'(3 * QUARTER_TURN));
    end else if (turn_pos >= 15'(2 * QUARTER_TURN)) begin
      quad = QUAD_2;
      rem  = REM_W'(turn_pos - 15'(2 * QUARTER_TURN));
    end else if (turn_pos >= 15'(QUARTER_TURN)) begin
      quad = QUAD_1;
      rem  = REM_W'(turn_pos - 15'(QUARTER_TURN));
    end else begin
      quad = QUAD_0;
      rem  = REM_W'(turn_pos);
    end
  end

  // Stage two register: remainder scaled to Q16 degrees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_side.idx  <= s1_idx;
    out_side.quad <= quad;
    out_z         <= Z_W'({rem, {ANGLE_SHIFT{1'b0}}});
  end

endmodule

`default_nettype wire

/* src/tasr_cordic.sv */
`default_nettype none

module tasr_cordic
  import tasr_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  input  wire  side_t                 in_side,
  input  wire  signed [Z_W-1:0]       in_z,
  output logic                        out_valid,
  output side_t                       out_side,
  output logic signed [XY_W-1:0]      out_x,
  output logic signed [XY_W-1:0]      out_y
);

  logic signed [XY_W-1:0] x_in [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_in [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_in [CORDIC_STAGES];
  side_t                  sd_in [CORDIC_STAGES];
  logic                   v_in  [CORDIC_STAGES];

  logic signed [XY_W-1:0] x_q  [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_q  [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_q  [CORDIC_STAGES];
  side_t                  sd_q [CORDIC_STAGES];
  logic                   v_q  [CORDIC_STAGES];

  // Each stage takes the register of the stage before it; the first takes
  // the unit vector pre-scaled by the inverse gain.
  always_comb begin
    x_in[0]  = CORDIC_GAIN_Q30;
    y_in[0]  = '0;
    z_in[0]  = in_z;
    sd_in[0] = in_side;
    v_in[0]  = in_valid;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      x_in[i]  = x_q[i-1];
      y_in[i]  = y_q[i-1];
      z_in[i]  = z_q[i-1];
      sd_in[i] = sd_q[i-1];
      v_in[i]  = v_q[i-1];
    end
  end

  // One micro-rotation per register stage; arithmetic shifts round down.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (!z_in[i][Z_W-1]) begin
        x_q[i] <= x_in[i] - (y_in[i] >>> i);
        y_q[i] <= y_in[i] + (x_in[i] >>> i);
        z_q[i] <= z_in[i] - atan_q16(i);
      end else begin
        x_q[i] <= x_in[i] + (y_in[i] >>> i);
        y_q[i] <= y_in[i] - (x_in[i] >>> i);
        z_q[i] <= z_in[i] + atan_q16(i);
      end
      sd_q[i] <= sd_in[i];
    end
  end

  // Valid bits travel with the vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        v_q[i] <= v_in[i];
      end
    end
  end

  assign out_valid = v_q[CORDIC_STAGES-1];
  assign out_side  = sd_q[CORDIC_STAGES-1];
  assign out_x     = x_q[CORDIC_STAGES-1];
  assign out_y     = y_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

/* src/tasr_back.sv */
`default_nettype none

module tasr_back
  import tasr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  input  wire  side_t                 in_side,
  input  wire  signed [XY_W-1:0]      in_x,
  input  wire  signed [XY_W-1:0]      in_y,
  output logic                        done,
  output logic [2:0]                  axis_index,
  output logic signed [15:0]          u_axis_x,
  output logic signed [15:0]          u_axis_y,
  output logic signed [15:0]          u_axis_z,
  output logic signed [15:0]          v_axis_x,
  output logic signed [15:0]          v_axis_y,
  output logic signed [15:0]          v_axis_z
);

  localparam int VAL_W = FRAC_BITS + 2;
  localparam int SH    = 30 - FRAC_BITS;
  localparam logic signed [RND_W-1:0] HALF = (RND_W'(1) <<< SH) >>> 1;
  localparam logic signed [RND_W-1:0] ONE  = RND_W'(1) <<< FRAC_BITS;

  logic signed [RND_W-1:0]  xr;
  logic signed [RND_W-1:0]  yr;
  logic signed [VAL_W-1:0]  cr_q;
  logic signed [VAL_W-1:0]  sr_q;
  side_t                    side_q;
  logic                     valid_q;

  logic signed [VAL_W-1:0]  c;
  logic signed [VAL_W-1:0]  s;
  logic signed [VAL_W-1:0]  zero;

  // Sign-extend or wrap a component into the 16-bit result field.
  function automatic logic [15:0] to_out(input logic signed [VAL_W-1:0] v);
    logic signed [31:0] e;
    e = 32'(v);
    return e[15:0];
  endfunction

  // Round half up to the output fraction and saturate to one.
  always_comb begin
    xr = (RND_W'(in_x) + HALF) >>> SH;
    yr = (RND_W'(in_y) + HALF) >>> SH;
    if (xr > ONE) begin
      xr = ONE;
    end else if (xr < -ONE) begin
      xr = -ONE;
    end
    if (yr > ONE) begin
      yr = ONE;
    end else if (yr < -ONE) begin
      yr = -ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cr_q   <= VAL_W'(xr);
    sr_q   <= VAL_W'(yr);
    side_q <= in_side;
  end

  // Unfold the quadrant.
  always_comb begin
    zero = '0;
    case (side_q.quad)
      QUAD_0: begin
        c = cr_q;
        s = sr_q;
      end
      QUAD_1: begin
        c = -sr_q;
        s = cr_q;
      end
      QUAD_2: begin
        c = -cr_q;
        s = -sr_q;
      end
      default: begin
        c = sr_q;
        s = -cr_q;
      end
    endcase
  end

  // Result register: place the rotated axes by direction pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    axis_index <= side_q.idx;
    case (side_q.idx) inside
      AXIS_POS_Z, AXIS_NEG_Z: begin
        u_axis_x <= to_out(c);
        u_axis_y <= to_out(s);
        u_axis_z <= to_out(zero);
        v_axis_x <= to_out(s);
        v_axis_y <= to_out(-c);
        v_axis_z <= to_out(zero);
      end
      AXIS_POS_X, AXIS_NEG_X: begin
        u_axis_x <= to_out(zero);
        u_axis_y <= to_out(c);
        u_axis_z <= to_out(s);
        v_axis_x <= to_out(zero);
        v_axis_y <= to_out(s);
        v_axis_z <= to_out(-c);
      end
      default: begin
        u_axis_x <= to_out(c);
        u_axis_y <= to_out(zero);
        u_axis_z <= to_out(-s);
        v_axis_x <= to_out(-s);
        v_axis_y <= to_out(zero);
        v_axis_z <= to_out(-c);
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/texture_axis_select_rotate_core.sv */
`default_nettype none

// Channel   Signals                                  Transfer
// input     start, busy, normal_x/y/z, rotation_deg  start high and busy low at a clock edge
// result    done, axis_index, u_axis_*, v_axis_*     done high for one cycle, always taken
//
// One item can be transferred in every cycle; busy is always low.
// Each result passes through the front end's stage one and stage two registers for
// direction choice and angle reduction, eighteen CORDIC stages, and the rounding
// and result registers of the back end for rounding and axis placement.
// Synchronous reset clears all valid bits; no result is lost or repeated,
// since nothing downstream can hold the pipeline.

module texture_axis_select_rotate_core
  import tasr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire  signed [15:0]  normal_x,
  input  wire  signed [15:0]  normal_y,
  input  wire  signed [15:0]  normal_z,
  input  wire  signed [15:0]  rotation_deg,
  output logic                done,
  output logic [2:0]          axis_index,
  output logic signed [15:0]  u_axis_x,
  output logic signed [15:0]  u_axis_y,
  output logic signed [15:0]  u_axis_z,
  output logic signed [15:0]  v_axis_x,
  output logic signed [15:0]  v_axis_y,
  output logic signed [15:0]  v_axis_z
);

  localparam int LATENCY = CORDIC_STAGES + 4;

  logic                   fr_valid;
  side_t                  fr_side;
  logic signed [Z_W-1:0]  fr_z;
  logic                   cd_valid;
  side_t                  cd_side;
  logic signed [XY_W-1:0] cd_x;
  logic signed [XY_W-1:0] cd_y;

  // The pipeline never stalls.
  assign busy = 1'b0;

  tasr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .rotation_deg (rotation_deg),
    .out_valid    (fr_valid),
    .out_side     (fr_side),
    .out_z        (fr_z)
  );

  tasr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_z      (fr_z),
    .out_valid (cd_valid),
    .out_side  (cd_side),
    .out_x     (cd_x),
    .out_y     (cd_y)
  );

  tasr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cd_valid),
    .in_side    (cd_side),
    .in_x       (cd_x),
    .in_y       (cd_y),
    .done       (done),
    .axis_index (axis_index),
    .u_axis_x   (u_axis_x),
    .u_axis_y   (u_axis_y),
    .u_axis_z   (u_axis_z),
    .v_axis_x   (v_axis_x),
    .v_axis_y   (v_axis_y),
    .v_axis_z   (v_axis_z)
  );

`ifndef NO_ASSERTIONS
  // Every result traces back to an input transfer a fixed latency earlier.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  // The z pair keeps its axes in the xy plane.
  a_z_pair_flat: assert property (@(posedge clk) disable iff (rst)
    done && (axis_index == AXIS_POS_Z || axis_index == AXIS_NEG_Z)
      |-> u_axis_z == 16'sd0 && v_axis_z == 16'sd0 && u_axis_x == -v_axis_y)
    else $error("z pair axes malformed");

  // The x pair keeps its axes in the yz plane.
  a_x_pair_flat: assert property (@(posedge clk) disable iff (rst)
    done && (axis_index == AXIS_POS_X || axis_index == AXIS_NEG_X)
      |-> u_axis_x == 16'sd0 && v_axis_x == 16'sd0 && u_axis_y == -v_axis_z)
    else $error("x pair axes malformed");

  // The y pair keeps its axes in the xz plane.
  a_y_pair_flat: assert property (@(posedge clk) disable iff (rst)
    done && (axis_index == AXIS_POS_Y || axis_index == AXIS_NEG_Y)
      |-> u_axis_y == 16'sd0 && v_axis_y == 16'sd0 && u_axis_z == v_axis_x)
    else $error("y pair axes malformed");
`endif

endmodule

`default_nettype wire

/* tb/texture_axis_select_rotate_core_tb.sv */
`default_nettype none

module texture_axis_select_rotate_core_tb;
  import tasr_pkg::*;

  localparam int  FRAC       = FRAC_BITS_DEFAULT;
  localparam int  SETTLE     = 30;
  localparam int  DRAIN_MAX  = 200;
  localparam int  RANDOM_CNT = 1900;

  // atan(2^-i) in Q16 degrees, one entry per CORDIC stage.
  localparam longint ATAN_Q16DEG [CORDIC_STAGES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] rot;
  } face_t;

  typedef struct packed {
    logic [2:0]         dir;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } axes_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic signed [15:0] normal_z = '0;
  logic signed [15:0] rotation_deg = '0;
  logic               busy;
  logic               done;
  logic [2:0]         axis_index;
  logic signed [15:0] u_axis_x;
  logic signed [15:0] u_axis_y;
  logic signed [15:0] u_axis_z;
  logic signed [15:0] v_axis_x;
  logic signed [15:0] v_axis_y;
  logic signed [15:0] v_axis_z;

  face_t pending_faces [$];
  axes_t expected_axes [$];
  face_t next_face;
  axes_t got_axes;
  axes_t want_axes;
  int    mismatches = 0;
  int    burst_left = 0;
  int    gap_left = 0;

  texture_axis_select_rotate_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .rotation_deg (rotation_deg),
    .done         (done),
    .axis_index   (axis_index),
    .u_axis_x     (u_axis_x),
    .u_axis_y     (u_axis_y),
    .u_axis_z     (u_axis_z),
    .v_axis_x     (v_axis_x),
    .v_axis_y     (v_axis_y),
    .v_axis_z     (v_axis_z)
  );

  always #10 clk = ~clk;

  // Rounds a Q30 value to the output fraction width and saturates it to +/-1.0.
  function automatic longint q30_to_frac(input longint q30);
    longint half;
    longint v;
    longint one;
    half = (FRAC < 30) ? (longint'(1) <<< (30 - FRAC - 1)) : 0;
    v    = (q30 + half) >>> (30 - FRAC);
    one  = longint'(1) <<< FRAC;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v;
  endfunction

  // Works out the chosen direction and the rotated texture axes for one face.
  function automatic axes_t predict_axes(input face_t f);
    logic [2:0] dir_code [6];
    longint     dots [6];
    longint     best;
    longint     ang;
    longint     rem;
    longint     x;
    longint     y;
    longint     z;
    longint     xs;
    longint     ys;
    longint     cr;
    longint     sr;
    longint     c;
    longint     s;
    logic [1:0] quad;
    axes_t      r;
    dir_code = '{AXIS_POS_Z, AXIS_NEG_Z, AXIS_POS_X, AXIS_NEG_X, AXIS_POS_Y, AXIS_NEG_Y};
    dots[0] = longint'(f.nz);
    dots[1] = -longint'(f.nz);
    dots[2] = longint'(f.nx);
    dots[3] = -longint'(f.nx);
    dots[4] = longint'(f.ny);
    dots[5] = -longint'(f.ny);
    best  = 0;
    r     = '0;
    r.dir = AXIS_POS_Z;
    // Strictly greater, so an earlier direction keeps a tie.
    for (int i = 0; i < 6; i++) begin
      if (dots[i] > best) begin
        best  = dots[i];
        r.dir = dir_code[i];
      end
    end

    // The y pair turns the other way round.
    ang = longint'(f.rot);
    if (r.dir == AXIS_POS_Y || r.dir == AXIS_NEG_Y) ang = -ang;
    ang = ang % FULL_TURN;
    if (ang < 0) ang += FULL_TURN;
    quad = 2'(ang / QUARTER_TURN);
    rem  = ang - longint'(quad) * QUARTER_TURN;

    // Rotation-mode CORDIC on the remainder within the quadrant.
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = rem <<< ANGLE_SHIFT;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16DEG[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16DEG[i];
      end
    end
    cr = q30_to_frac(x);
    sr = q30_to_frac(y);
    case (quad)
      QUAD_0: begin c = cr;  s = sr;  end
      QUAD_1: begin c = -sr; s = cr;  end
      QUAD_2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase

    // Place cosine and sine on the axes of the chosen direction.
    case (r.dir)
      AXIS_POS_Z, AXIS_NEG_Z: begin
        r.ux = 16'(c);  r.uy = 16'(s); r.uz = '0;
        r.vx = 16'(s);  r.vy = 16'(-c); r.vz = '0;
      end
      AXIS_POS_X, AXIS_NEG_X: begin
        r.ux = '0; r.uy = 16'(c); r.uz = 16'(s);
        r.vx = '0; r.vy = 16'(s); r.vz = 16'(-c);
      end
      default: begin
        r.ux = 16'(c);  r.uy = '0; r.uz = 16'(-s);
        r.vx = 16'(-s); r.vy = '0; r.vz = 16'(-c);
      end
    endcase
    return r;
  endfunction

  task automatic queue_face(input int nx, input int ny, input int nz, input int rot);
    face_t f;
    f.nx  = 16'(nx);
    f.ny  = 16'(ny);
    f.nz  = 16'(nz);
    f.rot = 16'(rot);
    pending_faces.push_back(f);
  endtask

  // Mostly in-range components, sometimes the extremes, sometimes any 16-bit value.
  function automatic int random_component();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return int'($signed(16'($urandom)));
    if (pick == 1) begin
      case ($urandom_range(0, 4))
        0:       return -16384;
        1:       return 16384;
        2:       return 0;
        3:       return -32768;
        default: return 32767;
      endcase
    end
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Mostly any angle, otherwise close to a quadrant boundary.
  function automatic int random_angle();
    if ($urandom_range(0, 3) == 0)
      return (int'($urandom_range(0, 10)) - 5) * QUARTER_TURN + int'($urandom_range(0, 4)) - 2;
    return int'($signed(16'($urandom)));
  endfunction

  task automatic queue_random_face();
    int c [3];
    int src;
    int dst;
    for (int i = 0; i < 3; i++) c[i] = random_component();
    // Force a tie in magnitude between two components now and then.
    if ($urandom_range(0, 4) == 0) begin
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      c[dst] = $urandom_range(0, 1) ? c[src] : -c[src];
    end
    queue_face(c[0], c[1], c[2], random_angle());
  endtask

  // Driver: sends faces in bursts, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_axes.push_back(predict_axes('{normal_x, normal_y, normal_z, rotation_deg}));
      if (start && busy) begin
        // The current transfer is still waiting; hold everything.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_faces.size() != 0) begin
        next_face = pending_faces.pop_front();
        normal_x     <= next_face.nx;
        normal_y     <= next_face.ny;
        normal_z     <= next_face.nz;
        rotation_deg <= next_face.rot;
        start        <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      got_axes = '{axis_index, u_axis_x, u_axis_y, u_axis_z, v_axis_x, v_axis_y, v_axis_z};
      if (expected_axes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual axis_index %0d",
                 $time, axis_index);
        mismatches++;
      end else begin
        want_axes = expected_axes.pop_front();
        check_field("axis_index", want_axes.dir, got_axes.dir);
        check_field("u_axis_x", want_axes.ux, got_axes.ux);
        check_field("u_axis_y", want_axes.uy, got_axes.uy);
        check_field("u_axis_z", want_axes.uz, got_axes.uz);
        check_field("v_axis_x", want_axes.vx, got_axes.vx);
        check_field("v_axis_y", want_axes.vy, got_axes.vy);
        check_field("v_axis_z", want_axes.vz, got_axes.vz);
      end
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    // A zero normal falls back to +z; an all-negative normal picks -z.
    queue_face(0, 0, 0, 0);
    queue_face(-1, -1, -1, -1);
    // One clear winner for each direction, with extreme angles.
    queue_face(0, 0, 16384, 32767);
    queue_face(0, 0, -16384, -32768);
    queue_face(16384, 0, 0, 5760);
    queue_face(-16384, 0, 0, 11520);
    queue_face(0, 16384, 0, 17280);
    queue_face(0, -16384, 0, 23040);
    queue_face(0, 16384, 0, -5760);
    queue_face(0, -16384, 0, 64);
    // Ties: the earlier direction keeps its place.
    queue_face(100, 100, 100, 1);
    queue_face(16384, 16384, -16384, 5759);
    queue_face(-200, 200, 0, 2880);
    queue_face(300, -300, -300, -23040);
    queue_face(-16384, -16384, -16384, 11519);
    // Normals outside the stated range are only compared.
    queue_face(32767, -32768, 0, -1);
    queue_face(-32768, 0, 0, -11520);
    queue_face(0, 32767, -32768, 17279);
    queue_face(-32768, -32768, -32768, 32767);
    queue_face(32767, 32767, 32767, -32768);
    for (int i = 0; i < RANDOM_CNT; i++) queue_random_face();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_faces.size() != 0 || start) @(posedge clk);
    for (int n = 0; n < DRAIN_MAX && expected_axes.size() != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_axes.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 left, actual %0d left",
               $time, expected_axes.size(), expected_axes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS texture_axis_select_rotate_core");
    end else begin
      $display("FAIL texture_axis_select_rotate_core");
    end
    $finish;
  end

  // Watchdog in case the run hangs.
  initial begin
    #2000000;
    $display("FAIL texture_axis_select_rotate_core");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/tasr_pkg.sv
src/tasr_front.sv
src/tasr_cordic.sv
src/tasr_back.sv
src/texture_axis_select_rotate_core.sv
tb/texture_axis_select_rotate_core_tb.sv
